FILE: rtl/cral_pkg.sv
// shared constants and action codes for the contiguous row allocator
// used by contiguous_row_allocator_unit and its testbench; no dependencies
package cral_pkg;

	localparam int NUM_ROWS   = 1024;
	localparam int OWNER_BITS = 8;
	localparam int ROW_W      = $clog2(NUM_ROWS);
	localparam int CNT_W      = ROW_W + 1;
	localparam int ACT_W      = 3;

	// action codes of a request beat
	localparam logic [ACT_W-1:0] ACT_BEGIN   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_RESERVE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_COMMIT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_ABORT   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FREE    = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CHECK   = 3'd5;
	localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd6;

	// response status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_NOFIT = 1'b1;

	// per-row flags held in the row map memory
	typedef struct packed {
		logic used;
		logic tent;
	} row_flags_t;

endpackage

FILE: rtl/cral_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module cral_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/contiguous_row_allocator_unit.sv
// first-fit contiguous row allocator for one memory core
// depends on cral_pkg and cral_ram (row flag map and row owner map)
//
// channel   dir   handshake              beat contents
// -------   ---   ---------------------  -------------------------------------
// cfg       in    cfg_valid / cfg_ready  active_rows
// req       in    req_valid / req_ready  action, row_count, row_index, owner_id
// rsp       out   rsp_valid / rsp_ready  status, start_row, range_free, rows_in_use
//
// one request at a time; the row maps sit in two rams read one row per cycle
// reserve: a scan of up to the managed rows, then a mark pass over the granted run
// check range: a scan of up to row_count rows; begin, commit, abort, free, clear:
// a full read-modify-write sweep over all NUM_ROWS rows; unknown action: no sweep
// after reset a clearing pass over all NUM_ROWS rows runs with req_ready low
// a finished response waits in its register; the next request is taken meanwhile
module contiguous_row_allocator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cral_pkg::CNT_W-1:0]       active_rows,
	// request
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [cral_pkg::ACT_W-1:0]       action,
	input  logic [cral_pkg::CNT_W-1:0]       row_count,
	input  logic [cral_pkg::ROW_W-1:0]       row_index,
	input  logic [cral_pkg::OWNER_BITS-1:0]  owner_id,
	// response
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic                             status,
	output logic [cral_pkg::ROW_W-1:0]       start_row,
	output logic                             range_free,
	output logic [cral_pkg::CNT_W-1:0]       rows_in_use
);

	typedef enum logic [4:0] {
		S_INIT = 5'b00001, // clearing pass over the flag map
		S_IDLE = 5'b00010,
		S_SCAN = 5'b00100, // read (modify write) sweep over the flag map
		S_MARK = 5'b01000, // tag the granted run tentative with its owner
		S_DONE = 5'b10000  // hand the result to the response register
	} state_t;

	state_t                           state_q;
	logic [cral_pkg::ACT_W-1:0]       op_q;
	logic [cral_pkg::CNT_W-1:0]       cnt_q;
	logic [cral_pkg::OWNER_BITS-1:0]  owner_q;
	logic [cral_pkg::CNT_W-1:0]       active_q;
	logic [cral_pkg::CNT_W-1:0]       addr_q;
	logic [cral_pkg::CNT_W-1:0]       end_q;
	logic                             stop_q;
	logic                             found_q;
	logic                             hit_q;
	logic                             chk_ok_q;
	logic [cral_pkg::CNT_W-1:0]       run_q;
	logic [cral_pkg::ROW_W-1:0]       run_start_q;
	logic [cral_pkg::CNT_W-1:0]       used_cnt_q;

	// read pipeline stage: data of row_s1 arrives from the rams
	logic                             rd_vld_s1;
	logic [cral_pkg::ROW_W-1:0]       row_s1;

	// response register
	logic                             rsp_valid_q;
	logic                             status_q;
	logic [cral_pkg::ROW_W-1:0]       start_row_q;
	logic                             range_free_q;
	logic [cral_pkg::CNT_W-1:0]       rows_in_use_q;

	// ram ports
	logic                             rd_en;
	logic [cral_pkg::ROW_W-1:0]       rd_addr;
	cral_pkg::row_flags_t             rd_flags;
	logic [cral_pkg::OWNER_BITS-1:0]  rd_owner;
	logic                             flg_wr_en;
	logic [cral_pkg::ROW_W-1:0]       flg_wr_addr;
	cral_pkg::row_flags_t             flg_wr_data;
	logic                             own_wr_en;

	logic [cral_pkg::CNT_W-1:0]       lim;
	logic                             accept;
	logic                             issue;
	logic                             proc;
	logic                             owner_hit;
	logic                             chk_ok;
	logic                             rsp_load;
	logic [cral_pkg::CNT_W-1:0]       first_ext;
	logic [cral_pkg::CNT_W-1:0]       addr_inc;

	// managed rows: values above the map size act as the map size
	assign lim = (active_q > cral_pkg::CNT_W'(cral_pkg::NUM_ROWS))
		? cral_pkg::CNT_W'(cral_pkg::NUM_ROWS) : active_q;

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;

	assign first_ext = {1'b0, row_index};
	assign chk_ok    = (row_count != '0) && (first_ext < lim) && (row_count <= lim - first_ext);
	assign addr_inc  = addr_q + cral_pkg::CNT_W'(1);

	// sweep issues one read per cycle until the end or an early stop
	assign issue     = (state_q == S_SCAN) && (addr_q < end_q) && !stop_q;
	assign rd_en     = issue;
	assign rd_addr   = addr_q[cral_pkg::ROW_W-1:0];
	assign proc      = rd_vld_s1 && !stop_q;
	assign owner_hit = (rd_owner == owner_q);

	// write side of the flag map: clearing pass, mark pass, or sweep write-back
	always_comb begin
		flg_wr_en   = 1'b0;
		flg_wr_addr = row_s1;
		flg_wr_data = '0;
		own_wr_en   = 1'b0;
		unique case (state_q)
			S_INIT: begin
				flg_wr_en   = 1'b1;
				flg_wr_addr = addr_q[cral_pkg::ROW_W-1:0];
			end
			S_MARK: begin
				flg_wr_en        = 1'b1;
				own_wr_en        = 1'b1;
				flg_wr_addr      = addr_q[cral_pkg::ROW_W-1:0];
				flg_wr_data.used = 1'b0;
				flg_wr_data.tent = 1'b1;
			end
			S_SCAN: begin
				unique case (op_q) inside
					cral_pkg::ACT_BEGIN, cral_pkg::ACT_ABORT: begin
						flg_wr_en        = rd_vld_s1;
						flg_wr_data.used = rd_flags.used;
						flg_wr_data.tent = 1'b0;
					end
					cral_pkg::ACT_COMMIT: begin
						flg_wr_en        = rd_vld_s1;
						flg_wr_data.used = rd_flags.used | rd_flags.tent;
						flg_wr_data.tent = 1'b0;
					end
					cral_pkg::ACT_FREE: begin
						// only committed rows go; tentative marks stay
						flg_wr_en        = rd_vld_s1;
						flg_wr_data.used = rd_flags.used & !owner_hit;
						flg_wr_data.tent = rd_flags.tent;
					end
					cral_pkg::ACT_CLEAR: begin
						flg_wr_en = rd_vld_s1;
					end
					default: begin
						flg_wr_en = 1'b0;
					end
				endcase
			end
			default: begin
				flg_wr_en = 1'b0;
			end
		endcase
	end

	cral_ram #(
		.WIDTH($bits(cral_pkg::row_flags_t)),
		.DEPTH(cral_pkg::NUM_ROWS)
	) u_flag_ram (
		.clk    (clk),
		.wr_en  (flg_wr_en),
		.wr_addr(flg_wr_addr),
		.wr_data(flg_wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_flags)
	);

	// owner tags: written only by the mark pass, read along with the flag map in every sweep
	cral_ram #(
		.WIDTH(cral_pkg::OWNER_BITS),
		.DEPTH(cral_pkg::NUM_ROWS)
	) u_owner_ram (
		.clk    (clk),
		.wr_en  (own_wr_en),
		.wr_addr(addr_q[cral_pkg::ROW_W-1:0]),
		.wr_data(owner_q),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_owner)
	);

	// response register frees as soon as the old beat is taken
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= cral_pkg::CNT_W'(cral_pkg::NUM_ROWS);
		end else if (cfg_valid && cfg_ready) begin
			active_q <= active_rows;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			op_q        <= cral_pkg::ACT_BEGIN;
			addr_q      <= '0;
			end_q       <= '0;
			stop_q      <= 1'b0;
			found_q     <= 1'b0;
			hit_q       <= 1'b0;
			chk_ok_q    <= 1'b0;
			run_q       <= '0;
			used_cnt_q  <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_INIT: begin
					addr_q <= addr_inc;
					if (addr_q == cral_pkg::CNT_W'(cral_pkg::NUM_ROWS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q     <= action;
						stop_q   <= 1'b0;
						found_q  <= 1'b0;
						hit_q    <= 1'b0;
						run_q    <= '0;
						chk_ok_q <= chk_ok;
						case (action) inside
							cral_pkg::ACT_RESERVE: begin
								addr_q  <= '0;
								end_q   <= lim;
								state_q <= (row_count == '0 || lim == '0) ? S_DONE : S_SCAN;
							end
							cral_pkg::ACT_CHECK: begin
								addr_q  <= first_ext;
								end_q   <= first_ext + row_count;
								state_q <= chk_ok ? S_SCAN : S_DONE;
							end
							cral_pkg::ACT_BEGIN, cral_pkg::ACT_ABORT, cral_pkg::ACT_COMMIT,
							cral_pkg::ACT_FREE, cral_pkg::ACT_CLEAR: begin
								addr_q  <= '0;
								end_q   <= cral_pkg::CNT_W'(cral_pkg::NUM_ROWS);
								state_q <= S_SCAN;
								if (action == cral_pkg::ACT_CLEAR) begin
									used_cnt_q <= '0;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue) begin
						addr_q <= addr_inc;
					end
					if (proc) begin
						case (op_q)
							cral_pkg::ACT_RESERVE: begin
								if (rd_flags.used || rd_flags.tent) begin
									run_q <= '0;
								end else begin
									if (run_q == '0) begin
										run_start_q <= row_s1;
									end
									run_q <= run_q + cral_pkg::CNT_W'(1);
									if (run_q + cral_pkg::CNT_W'(1) == cnt_q) begin
										found_q <= 1'b1;
										stop_q  <= 1'b1;
									end
								end
							end
							cral_pkg::ACT_CHECK: begin
								if (rd_flags.used) begin
									hit_q  <= 1'b1;
									stop_q <= 1'b1;
								end
							end
							cral_pkg::ACT_COMMIT: begin
								if (rd_flags.tent && !rd_flags.used) begin
									used_cnt_q <= used_cnt_q + cral_pkg::CNT_W'(1);
								end
							end
							cral_pkg::ACT_FREE: begin
								if (rd_flags.used && owner_hit) begin
									used_cnt_q <= used_cnt_q - cral_pkg::CNT_W'(1);
								end
							end
							default: begin
							end
						endcase
					end
					// leave once the read pipe has drained
					if (!issue && !rd_vld_s1) begin
						if (op_q == cral_pkg::ACT_RESERVE && found_q) begin
							addr_q  <= {1'b0, run_start_q};
							end_q   <= {1'b0, run_start_q} + cnt_q;
							state_q <= S_MARK;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_MARK: begin
					addr_q <= addr_inc;
					if (addr_inc == end_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload, read stage row and response fields, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_q   <= row_count;
			owner_q <= owner_id;
		end
		row_s1 <= addr_q[cral_pkg::ROW_W-1:0];
		if (rsp_load) begin
			status_q      <= (op_q == cral_pkg::ACT_RESERVE && !found_q)
				? cral_pkg::STATUS_NOFIT : cral_pkg::STATUS_OK;
			start_row_q   <= (op_q == cral_pkg::ACT_RESERVE && found_q) ? run_start_q : '0;
			range_free_q  <= (op_q == cral_pkg::ACT_CHECK) && chk_ok_q && !hit_q;
			rows_in_use_q <= used_cnt_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign start_row   = start_row_q;
	assign range_free  = range_free_q;
	assign rows_in_use = rows_in_use_q;

	// a sweep never reads the row it is writing back
	a_no_rw_same_row: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && flg_wr_en) |-> (rd_addr != flg_wr_addr))
		else $error("row map read and write hit the same row");

	// returned read data only shows up inside a sweep
	a_rd_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN))
		else $error("row read returned outside a sweep");

	// committed row count never exceeds the map
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_cnt_q <= cral_pkg::CNT_W'(cral_pkg::NUM_ROWS))
		else $error("rows in use out of range");

	// a failed reserve reports start row zero
	a_fail_start: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q == cral_pkg::STATUS_NOFIT) |-> (start_row_q == '0))
		else $error("failed reserve with nonzero start row");

	// the owner map is written only while marking a granted run
	a_mark_owner: assert property (@(posedge clk) disable iff (!arst_n)
		own_wr_en |-> (op_q == cral_pkg::ACT_RESERVE && found_q))
		else $error("owner write without a granted run");

endmodule

FILE: tb/contiguous_row_allocator_unit_test.sv
`timescale 1ns / 1ps
// self-checking testbench for contiguous_row_allocator_unit: directed and random
// allocation traffic, scoreboard class with its own row map; needs cral_pkg and the rtl
module contiguous_row_allocator_unit_test;
	import cral_pkg::*;

	// action 7 is not decoded by the block; its beat must be zero but for rows_in_use
	localparam logic [ACT_W-1:0] ACT_UNKNOWN = 3'd7;
	// cycles with no handshake at all before the run is declared hung
	localparam int HANG_LIMIT = 20000;
	// settling time covers the longest single action, a full reserve scan plus marking
	localparam int SETTLE_CYCLES = 2 * NUM_ROWS + 64;

	typedef struct {
		logic [ACT_W-1:0]      action;
		logic [CNT_W-1:0]      row_count;
		logic [ROW_W-1:0]      row_index;
		logic [OWNER_BITS-1:0] owner_id;
	} alloc_req_t;

	typedef struct {
		logic             status;
		logic [ROW_W-1:0] start_row;
		logic             range_free;
		logic [CNT_W-1:0] rows_in_use;
	} alloc_rsp_t;

	// row map mirror: predicts each response and holds the ones still to come
	class row_map_scoreboard;
		bit                    used[NUM_ROWS];
		bit                    tent[NUM_ROWS];
		logic [OWNER_BITS-1:0] owner[NUM_ROWS];
		int unsigned           used_count;
		int unsigned           active;
		alloc_rsp_t            expected_q[$];
		int                    errors;

		function new();
			foreach (used[i]) begin
				used[i] = 1'b0;
				tent[i] = 1'b0;
			end
			used_count = 0;
			active     = NUM_ROWS;
			errors     = 0;
		endfunction

		function void set_active(logic [CNT_W-1:0] v);
			active = 32'(v);
		endfunction

		function int unsigned managed();
			return (active > NUM_ROWS) ? NUM_ROWS : active;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_request(alloc_req_t r);
			int unsigned lim, cnt, first, run, run_start, i;
			bit          found;
			alloc_rsp_t  e;
			lim   = managed();
			cnt   = 32'(r.row_count);
			first = 32'(r.row_index);
			e     = '{STATUS_OK, '0, 1'b0, '0};
			case (r.action)
				ACT_BEGIN, ACT_ABORT: begin
					foreach (tent[j]) tent[j] = 1'b0;
				end
				ACT_RESERVE: begin
					// first fit over rows that are neither used nor tentative
					found     = 1'b0;
					run       = 0;
					run_start = 0;
					if (cnt != 0) begin
						for (i = 0; i < lim && !found; i++) begin
							if (used[i] || tent[i]) begin
								run = 0;
							end else begin
								if (run == 0) run_start = i;
								run++;
								if (run == cnt) found = 1'b1;
							end
						end
					end
					if (found) begin
						for (i = run_start; i < run_start + cnt; i++) begin
							tent[i]  = 1'b1;
							owner[i] = r.owner_id;
						end
						e.start_row = run_start[ROW_W-1:0];
					end else begin
						e.status = STATUS_NOFIT;
					end
				end
				ACT_COMMIT: begin
					// commit sweeps every row, also those beyond the managed limit
					for (i = 0; i < NUM_ROWS; i++) begin
						if (tent[i]) begin
							tent[i] = 1'b0;
							if (!used[i]) begin
								used[i] = 1'b1;
								used_count++;
							end
						end
					end
				end
				ACT_FREE: begin
					// only committed rows go; tentative ones of the owner stay
					for (i = 0; i < NUM_ROWS; i++) begin
						if (used[i] && owner[i] == r.owner_id) begin
							used[i] = 1'b0;
							used_count--;
						end
					end
				end
				ACT_CHECK: begin
					if (cnt != 0 && first < lim && cnt <= lim - first) begin
						e.range_free = 1'b1;
						for (i = first; i < first + cnt; i++)
							if (used[i]) e.range_free = 1'b0;
					end
				end
				ACT_CLEAR: begin
					foreach (used[j]) begin
						used[j] = 1'b0;
						tent[j] = 1'b0;
					end
					used_count = 0;
				end
				default: ;
			endcase
			e.rows_in_use = used_count[CNT_W-1:0];
			expected_q.insert(expected_q.size(), e);
		endfunction

		function void check_response(alloc_rsp_t got);
			alloc_rsp_t e;
			if (expected_q.size() == 0) begin
				$error("response beat with nothing expected: status %0d start_row %0d",
					got.status, got.start_row);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.status !== e.status) begin
				$error("status mismatch: expected %0d, actual %0d", e.status, got.status);
				errors++;
			end
			if (got.start_row !== e.start_row) begin
				$error("start_row mismatch: expected %0d, actual %0d", e.start_row,
					got.start_row);
				errors++;
			end
			if (got.range_free !== e.range_free) begin
				$error("range_free mismatch: expected %0d, actual %0d", e.range_free,
					got.range_free);
				errors++;
			end
			if (got.rows_in_use !== e.rows_in_use) begin
				$error("rows_in_use mismatch: expected %0d, actual %0d", e.rows_in_use,
					got.rows_in_use);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CNT_W-1:0]      active_rows;
	logic                  req_valid;
	logic                  req_ready;
	logic [ACT_W-1:0]      action;
	logic [CNT_W-1:0]      row_count;
	logic [ROW_W-1:0]      row_index;
	logic [OWNER_BITS-1:0] owner_id;
	logic                  rsp_valid;
	logic                  rsp_ready;
	logic                  status;
	logic [ROW_W-1:0]      start_row;
	logic                  range_free;
	logic [CNT_W-1:0]      rows_in_use;

	row_map_scoreboard sb = new();
	bit                steady;      // when set, neither side idles
	int                idle_cycles;

	contiguous_row_allocator_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.active_rows (active_rows),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.action      (action),
		.row_count   (row_count),
		.row_index   (row_index),
		.owner_id    (owner_id),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.start_row   (start_row),
		.range_free  (range_free),
		.rows_in_use (rows_in_use)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 20);
		return $urandom_range(40, 150);
	endfunction

	// sampled before the edge's updates land, so every handshake is seen once and in order
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			sb.set_active(active_rows);
		if (req_valid && req_ready)
			sb.note_request(alloc_req_t'{action, row_count, row_index, owner_id});
		if (rsp_valid && rsp_ready)
			sb.check_response(alloc_rsp_t'{status, start_row, range_free, rows_in_use});
	end

	// hang guard: any beat on any channel restarts the count
	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// response side: stalls of random length between bursts of ready
	initial begin
		forever begin
			int unsigned n;
			n = pick_gap();
			if (n > 0) begin
				rsp_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// one request beat; valid is only lowered when a gap really follows,
	// so back-to-back beats keep it high without a second update in one step
	task automatic send_request(input logic [ACT_W-1:0] act, input logic [CNT_W-1:0] cnt,
			input logic [ROW_W-1:0] idx, input logic [OWNER_BITS-1:0] own);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		action    <= act;
		row_count <= cnt;
		row_index <= idx;
		owner_id  <= own;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	// stop sending and wait until every response has come back; the loop waits on the clock
	// before its first look so that a beat taken at the current edge is already counted
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_active_rows(input logic [CNT_W-1:0] v);
		cfg_valid   <= 1'b1;
		active_rows <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [OWNER_BITS-1:0] pick_owner();
		// a small pool so that frees keep finding rows
		if ($urandom_range(0, 4) != 0) return OWNER_BITS'($urandom_range(0, 7));
		return OWNER_BITS'($urandom_range(0, 255));
	endfunction

	function automatic logic [CNT_W-1:0] pick_count(input int unsigned lim);
		int unsigned top, r;
		top = (lim == 0) ? 1 : lim;
		r   = $urandom_range(0, 99);
		if (r < 55) return CNT_W'($urandom_range(1, (top < 16) ? top : 16));
		if (r < 80) return CNT_W'($urandom_range(1, top));
		if (r < 88) return CNT_W'(top);
		if (r < 93) return '0;
		return CNT_W'($urandom_range(0, 2047));
	endfunction

	task automatic directed_checks();
		// undecoded action with every field at its top value
		send_request(ACT_UNKNOWN, 11'd2047, 10'd1023, 8'd255);
		send_request(ACT_BEGIN, '0, '0, '0);
		// zero length and oversized reserve both miss
		send_request(ACT_RESERVE, 11'd0, 10'd5, 8'd1);
		send_request(ACT_RESERVE, 11'd2047, 10'd0, 8'd1);
		// whole map to one owner, then the map is full
		send_request(ACT_RESERVE, 11'd1024, '0, 8'd255);
		send_request(ACT_COMMIT, '0, '0, '0);
		send_request(ACT_CHECK, 11'd1024, 10'd0, '0);
		send_request(ACT_RESERVE, 11'd1, '0, 8'd3);
		send_request(ACT_FREE, '0, '0, 8'd255);
		send_request(ACT_CHECK, 11'd1024, 10'd0, '0);
		// range running past the managed rows, and a zero-length range
		send_request(ACT_CHECK, 11'd2, 10'd1023, '0);
		send_request(ACT_CHECK, 11'd0, 10'd7, '0);
		// aborted reservation must leave no trace
		send_request(ACT_RESERVE, 11'd3, '0, 8'd0);
		send_request(ACT_RESERVE, 11'd5, '0, 8'd1);
		send_request(ACT_ABORT, '0, '0, '0);
		send_request(ACT_RESERVE, 11'd2, '0, 8'd2);
		send_request(ACT_RESERVE, 11'd4, '0, 8'd3);
		send_request(ACT_COMMIT, '0, '0, '0);
		// hole left by a free is found first
		send_request(ACT_FREE, '0, '0, 8'd2);
		send_request(ACT_RESERVE, 11'd1, '0, 8'd85);
		send_request(ACT_COMMIT, '0, '0, '0);
		// free of an owner with only tentative rows keeps them tentative
		send_request(ACT_RESERVE, 11'd3, '0, 8'd7);
		send_request(ACT_FREE, '0, '0, 8'd7);
		send_request(ACT_FREE, '0, '0, 8'd170);
		send_request(ACT_COMMIT, '0, '0, '0);
		send_request(ACT_CHECK, 11'd3, 10'd2, '0);
		send_request(ACT_CLEAR, '0, '0, '0);
	endtask

	// mostly begin / reserves / commit-or-abort sequences, the rest loose actions and noise
	task automatic random_phase(input int target);
		int          sent, k, r;
		int unsigned lim, idx;
		sent = 0;
		while (sent < target) begin
			lim = sb.managed();
			r   = $urandom_range(0, 99);
			if (r < 65) begin
				if ($urandom_range(0, 4) != 0) begin
					send_request(ACT_BEGIN, CNT_W'($urandom), ROW_W'($urandom),
						OWNER_BITS'($urandom));
					sent++;
				end
				k = $urandom_range(1, 4);
				repeat (k) send_request(ACT_RESERVE, pick_count(lim), ROW_W'($urandom),
					pick_owner());
				sent += k;
				send_request(($urandom_range(0, 4) != 0) ? ACT_COMMIT : ACT_ABORT,
					CNT_W'($urandom), ROW_W'($urandom), OWNER_BITS'($urandom));
				sent++;
			end else if (r < 78) begin
				send_request(ACT_FREE, CNT_W'($urandom), ROW_W'($urandom), pick_owner());
				sent++;
			end else if (r < 93) begin
				idx = (lim > 0 && $urandom_range(0, 9) < 7) ?
					$urandom_range(0, lim - 1) : $urandom_range(0, 1023);
				send_request(ACT_CHECK,
					(idx < lim && $urandom_range(0, 9) < 6) ?
						CNT_W'($urandom_range(1, lim - idx)) : pick_count(lim),
					ROW_W'(idx), OWNER_BITS'($urandom));
				sent++;
			end else if (r < 95) begin
				send_request(ACT_CLEAR, CNT_W'($urandom), ROW_W'($urandom),
					OWNER_BITS'($urandom));
				sent++;
			end else begin
				// loose reserve, stray commit or an undecoded action
				case ($urandom_range(0, 2))
					0: send_request(ACT_RESERVE, pick_count(lim), ROW_W'($urandom),
						pick_owner());
					1: send_request(ACT_COMMIT, CNT_W'($urandom), ROW_W'($urandom),
						OWNER_BITS'($urandom));
					default: send_request(ACT_UNKNOWN, CNT_W'($urandom), ROW_W'($urandom),
						OWNER_BITS'($urandom));
				endcase
				sent++;
			end
		end
	endtask

	initial begin
		logic [CNT_W-1:0] rows_setting;
		steady      = 1'b0;
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		active_rows <= '0;
		req_valid   <= 1'b0;
		action      <= ACT_BEGIN;
		row_count   <= '0;
		row_index   <= '0;
		owner_id    <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		write_active_rows(11'd1024);
		directed_checks();

		// settings run through extremes; shrinking after a full-size phase
		// leaves used rows beyond the limit for commit and free to meet
		for (int p = 0; p < 11; p++) begin
			drain();
			case (p)
				0: rows_setting = 11'd1024;
				1: rows_setting = 11'd8;
				2: rows_setting = 11'd1;
				3: rows_setting = 11'd0;
				4: rows_setting = 11'd2047;
				5: rows_setting = 11'd100;
				6: rows_setting = 11'd1365;
				7: rows_setting = 11'd682;
				8: rows_setting = CNT_W'($urandom_range(1, 1024));
				9: rows_setting = 11'd513;
				default: rows_setting = 11'd1024;
			endcase
			write_active_rows(rows_setting);
			steady = (p == 2 || p == 7);
			random_phase(50);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
